### design/median_filter_3x3_defines.svh
// Assertion macros shared by the median filter checker.
// Each macro samples on i_clk, so it is meant for a scope that has i_clk and i_rst_n.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define MF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define MF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after reset is sampled low.
`define MF_ASSERT_RESET(label, cons, msg) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error(msg);

`endif

### design/mf_pkg.sv
package mf_pkg;

    // Image geometry limits.
    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 8;
    localparam int ADDR_BITS    = $clog2(MAX_WIDTH);
    localparam int MIN_DIM      = 3;
    localparam int HEIGHT_LIMIT = 4096;

    // Counter and register widths.
    localparam int COL_BITS      = 11;
    localparam int ROW_BITS      = 12;
    localparam int HGT_BITS      = 13;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 13;

    // Register reset values.
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Input command code for a drain step.
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic [PIXEL_BITS-1:0]       t_pix;
    typedef logic [2:0][PIXEL_BITS-1:0]  t_trip;
    typedef logic [COL_BITS-1:0]         t_col;
    typedef logic [ROW_BITS-1:0]         t_row;
    typedef logic [HGT_BITS-1:0]         t_hgt;

endpackage

### design/median_filter_3x3.sv
// Path: stage 1, stage 2, output register. Each line store has a single read and write port.
// In image terms each result trails its pixel by one row plus one pixel (image_width + 1 beats).
// Throughput: one beat per cycle unless i_ready stalls the output.
// Reset: synchronous, active low; clears counters, window and valid flags, and loads
// image_width = 640 and image_height = 480. The line stores are not cleared.
module median_filter_3x3 (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mf_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_command,
    input  logic [mf_pkg::PIXEL_BITS-1:0]    i_pixel,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [mf_pkg::PIXEL_BITS-1:0]    o_filtered_pixel,
    output logic                             o_frame_end
);
    import mf_pkg::*;

    // Configuration and position state.
    t_col r_img_w;
    t_hgt r_img_h;
    t_col r_in_col;
    t_row r_in_row;
    t_col r_out_col;
    t_row r_out_row;
    logic r_drain;

    t_col n_in_col;
    t_row n_in_row;
    t_col n_out_col;
    t_row n_out_row;
    logic n_drain;

    // Front-end decode.
    t_col w_used;
    t_hgt h_used;
    logic acc;
    logic is_drain;
    logic do_restart;
    logic takes;
    logic emits;
    t_col cur_col;
    t_row cur_row;
    t_col cur_ocol;
    t_row cur_orow;
    logic in_col_wrap;
    logic in_row_wrap;
    logic out_col_wrap;
    logic out_row_last;
    logic out_last;
    logic out_border;
    logic [ADDR_BITS-1:0] mem_addr;
    t_pix new_pix;

    // Line stores and their read registers.
    t_pix r_upper [MAX_WIDTH];
    t_pix r_lower [MAX_WIDTH];
    t_pix r_rd_top;
    t_pix r_rd_mid;

    // Stage 1: column fetch and window shift.
    logic                 r_s1_v;
    logic [ADDR_BITS-1:0] r_s1_addr;
    t_pix                 r_s1_pix;
    logic                 r_s1_emit;
    logic                 r_s1_border;
    logic                 r_s1_last;
    logic                 r_s1_byp;
    t_pix                 r_byp_top;
    t_pix                 r_byp_mid;
    t_pix                 col_top;
    t_pix                 col_mid;

    // Window: original pixels and per-column sorted copies.
    t_pix  r_win [9];
    t_trip r_scol [3];

    // Stage 2 and output register.
    logic r_s2_v;
    logic r_s2_border;
    logic r_s2_last;
    logic r_out_v;
    t_pix r_out_pix;
    logic r_out_end;

    // Flow control.
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s1_go;
    logic s2_go;

    // Returns {larger, smaller}.
    function automatic logic [2*PIXEL_BITS-1:0] order2(input t_pix x, input t_pix y);
        return (x > y) ? {x, y} : {y, x};
    endfunction

    // Sorts three pixels, smallest in element 0.
    function automatic t_trip sort3(input t_pix x, input t_pix y, input t_pix z);
        t_pix p [3];
        p[0] = x;
        p[1] = y;
        p[2] = z;
        {p[2], p[1]} = order2(p[1], p[2]);
        {p[1], p[0]} = order2(p[0], p[1]);
        {p[2], p[1]} = order2(p[1], p[2]);
        return {p[2], p[1], p[0]};
    endfunction

    // Median of nine from three already sorted columns.
    function automatic t_pix median9(input t_trip a, input t_trip b, input t_trip c);
        t_pix p [9];
        p[0] = a[0];
        p[1] = a[1];
        p[2] = a[2];
        p[3] = b[0];
        p[4] = b[1];
        p[5] = b[2];
        p[6] = c[0];
        p[7] = c[1];
        p[8] = c[2];
        {p[3], p[0]} = order2(p[0], p[3]);
        {p[8], p[5]} = order2(p[5], p[8]);
        {p[7], p[4]} = order2(p[4], p[7]);
        {p[6], p[3]} = order2(p[3], p[6]);
        {p[4], p[1]} = order2(p[1], p[4]);
        {p[5], p[2]} = order2(p[2], p[5]);
        {p[7], p[4]} = order2(p[4], p[7]);
        {p[2], p[4]} = order2(p[4], p[2]);
        {p[4], p[6]} = order2(p[6], p[4]);
        {p[2], p[4]} = order2(p[4], p[2]);
        return p[4];
    endfunction

    // Clamp the programmed geometry to the supported range.
    always_comb begin
        if (r_img_w < COL_BITS'(MIN_DIM)) begin
            w_used = COL_BITS'(MIN_DIM);
        end else if (r_img_w > COL_BITS'(MAX_WIDTH)) begin
            w_used = COL_BITS'(MAX_WIDTH);
        end else begin
            w_used = r_img_w;
        end
        if (r_img_h < HGT_BITS'(MIN_DIM)) begin
            h_used = HGT_BITS'(MIN_DIM);
        end else if (r_img_h > HGT_BITS'(HEIGHT_LIMIT)) begin
            h_used = HGT_BITS'(HEIGHT_LIMIT);
        end else begin
            h_used = r_img_h;
        end
    end

    // The pipeline advances from the output side back to the input.
    assign out_free = !r_out_v || i_ready;
    assign s2_free  = !r_s2_v || out_free;
    assign s1_free  = !r_s1_v || s2_free;
    assign s1_go    = r_s1_v && s2_free;
    assign s2_go    = r_s2_v && out_free;
    assign o_ready  = s1_free;
    assign acc      = i_valid && s1_free;

    // Decode the incoming beat against the current frame position.
    // A pixel after the frame's end, or out of the frame, restarts at the top left corner.
    always_comb begin
        is_drain   = (i_command == CMD_DRAIN);
        do_restart = !is_drain &&
                     (r_drain || (r_in_col >= w_used) || (HGT_BITS'(r_in_row) >= h_used));
        takes      = !is_drain || r_drain;
        cur_col    = do_restart ? '0 : r_in_col;
        cur_row    = do_restart ? '0 : r_in_row;
        cur_ocol   = do_restart ? '0 : r_out_col;
        cur_orow   = do_restart ? '0 : r_out_row;
        if (is_drain) begin
            emits = r_drain;
        end else begin
            emits = (cur_row >= ROW_BITS'(2)) || ((cur_row == ROW_BITS'(1)) && (cur_col != '0));
        end
        in_col_wrap  = (cur_col == w_used - 1'b1);
        in_row_wrap  = (HGT_BITS'(cur_row) == h_used - 1'b1);
        out_col_wrap = (cur_ocol == w_used - 1'b1);
        out_row_last = (HGT_BITS'(cur_orow) == h_used - 1'b1);
        out_last     = out_row_last && out_col_wrap;
        out_border   = (cur_orow == '0) || out_row_last || (cur_ocol == '0) || out_col_wrap;
        mem_addr     = cur_col[ADDR_BITS-1:0];
        new_pix      = is_drain ? '0 : i_pixel;
    end

    // Next frame position.
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_drain   = r_drain;
        if (takes) begin
            if (is_drain) begin
                n_in_col = r_in_col + 1'b1;
            end else begin
                n_in_col = in_col_wrap ? '0 : cur_col + 1'b1;
                if (in_col_wrap) begin
                    n_in_row = in_row_wrap ? '0 : cur_row + 1'b1;
                end else begin
                    n_in_row = cur_row;
                end
                n_drain = in_col_wrap && in_row_wrap;
            end
            n_out_col = cur_ocol;
            n_out_row = cur_orow;
        end
        if (emits) begin
            if (out_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_drain   = 1'b0;
            end else if (out_col_wrap) begin
                n_out_col = '0;
                n_out_row = cur_orow + 1'b1;
            end else begin
                n_out_col = cur_ocol + 1'b1;
            end
        end
    end

    // Configuration registers and frame position; a register write restarts the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w   <= COL_BITS'(WIDTH_RESET);
            r_img_h   <= HGT_BITS'(HEIGHT_RESET);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_drain   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[COL_BITS-1:0];
                REG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[HGT_BITS-1:0];
            endcase
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_drain   <= 1'b0;
        end else if (acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_drain   <= n_drain;
        end
    end

    // Effective column for the beat in stage 1. When the previous beat wrote the same
    // address at the edge this one was read, the read data is stale and the bypass wins.
    assign col_top = r_s1_byp ? r_byp_top : r_rd_top;
    assign col_mid = r_s1_byp ? r_byp_mid : r_rd_mid;

    // Line stores: read when a beat is taken, written when it leaves stage 1.
    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_upper[r_s1_addr] <= col_mid;
            r_lower[r_s1_addr] <= r_s1_pix;
        end
        if (acc && takes) begin
            r_rd_top <= r_upper[mem_addr];
            r_rd_mid <= r_lower[mem_addr];
        end
    end

    // Stage 1 control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_free) begin
            r_s1_v <= acc && takes;
        end
    end

    // Stage 1 payload and bypass capture.
    always_ff @(posedge i_clk) begin
        if (acc && takes) begin
            r_s1_addr   <= mem_addr;
            r_s1_pix    <= new_pix;
            r_s1_emit   <= emits;
            r_s1_border <= out_border;
            r_s1_last   <= out_last;
            r_s1_byp    <= s1_go && (r_s1_addr == mem_addr);
            r_byp_top   <= col_mid;
            r_byp_mid   <= r_s1_pix;
        end
    end

    // Window shift: one new column enters on the right as the beat leaves stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_scol[i] <= '0;
            end
        end else if (s1_go) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2]  <= col_top;
            r_win[5]  <= col_mid;
            r_win[8]  <= r_s1_pix;
            r_scol[0] <= r_scol[1];
            r_scol[1] <= r_scol[2];
            r_scol[2] <= sort3(col_top, col_mid, r_s1_pix);
        end
    end

    // Stage 2 holds the flags of a beat that produces a result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= s1_go && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_border <= r_s1_border;
            r_s2_last   <= r_s1_last;
        end
    end

    // Output register: the median, or the window centre at a border.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_pix <= r_s2_border ? r_win[4] : median9(r_scol[0], r_scol[1], r_scol[2]);
            r_out_end <= r_s2_last;
        end
    end

    assign o_valid          = r_out_v;
    assign o_filtered_pixel = r_out_pix;
    assign o_frame_end      = r_out_end;

endmodule

### design/median_filter_3x3_chk.sv
`include "median_filter_3x3_defines.svh"

module median_filter_3x3_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [mf_pkg::PIXEL_BITS-1:0] o_filtered_pixel,
    input logic                          o_frame_end
);

    // A result beat that is not taken stays put.
    `MF_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_filtered_pixel) && $stable(o_frame_end), "stalled result beat changed")

    // With the output register empty, nothing can hold back the input.
    `MF_ASSERT_IMPL(a_ready_when_empty, !o_valid, o_ready, "input stalled with empty output")

    // Reset empties the pipeline.
    `MF_ASSERT_RESET(a_reset_empty, !o_valid && o_ready, "pipeline not empty after reset")

endmodule

bind median_filter_3x3 median_filter_3x3_chk u_chk (.*);
